// ----- design/dabs_pkg.sv -----
package dabs_pkg;

    // Field widths fixed by the item formats.
    localparam int MODEL_W   = 2;
    localparam int TAG_W     = 16;
    localparam int TIME_W    = 32;
    localparam int DEC_W     = 20;
    localparam int BSIZE_W   = 5;
    localparam int SLACK_W   = 32;
    localparam int EST_W     = 24;

    // Signed width that holds target - exec - decode - margin.
    localparam int BASE_W    = 22;

    // Configuration register widths, indexes and reset values.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int TARGET_W   = 20;
    localparam int MARGIN_W   = 17;
    localparam int MAXB_W     = 20;
    localparam int EXEC_W     = 64;
    localparam int MODELS_W   = 3;
    localparam int EXEC_FIELD_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXB   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXEC   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODELS = 3'd4;

    localparam logic [TARGET_W-1:0] TARGET_RESET = 20'd50000;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 17'd1000;
    localparam logic [MAXB_W-1:0]   MAXB_RESET   = 20'd541200;
    localparam logic [EXEC_W-1:0]   EXEC_RESET   = 64'd0;
    localparam logic [MODELS_W-1:0] MODELS_RESET = 3'd1;

    // Decode estimate: microseconds with four fraction bits, 2.0 ms after reset.
    localparam logic [EST_W-1:0] EST_RESET = 24'd32000;

    // x / 5 == (x * ceil(2^34 / 5)) >> 34 for every x below 2^32.
    localparam logic [31:0] DIV5_RECIP = 32'hCCCC_CCCD;
    localparam int          DIV5_SHIFT = 34;

    localparam logic signed [SLACK_W-1:0] SLACK_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SLACK_W-1:0] SLACK_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        OP_ARRIVAL = 2'd0,
        OP_POLL    = 2'd1,
        OP_DECODE  = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_ACCEPTED = 3'd0,
        KIND_REJECTED = 3'd1,
        KIND_WAITING  = 3'd2,
        KIND_EMPTY    = 3'd3,
        KIND_MEMBER   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_AGE,
        ST_CMP,
        ST_DECIDE,
        ST_FETCH,
        ST_EMIT
    } sched_state_t;

    typedef struct packed {
        op_t                op;
        logic [MODEL_W-1:0] model;
        logic [TAG_W-1:0]   request_tag;
        logic [TIME_W-1:0]  now_us;
        logic [DEC_W-1:0]   decode_us;
    } in_item_t;

    typedef struct packed {
        kind_t                     kind;
        logic [MODEL_W-1:0]        picked_model;
        logic [TAG_W-1:0]          out_tag;
        logic [BSIZE_W-1:0]        batch_size;
        logic                      last;
        logic signed [SLACK_W-1:0] slack_us;
    } out_item_t;

endpackage

// ----- design/dabs_ram.sv -----
module dabs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/dabs_ema.sv -----
module dabs_ema (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [dabs_pkg::DEC_W-1:0] decode_us,
    output logic [dabs_pkg::EST_W-1:0] est,
    output logic                       busy
);
    import dabs_pkg::*;

    localparam int ACC_W  = EST_W + 4;
    localparam int PROD_W = ACC_W - 1 + 32;

    logic [EST_W-1:0]  est_reg;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic              acc_vld_reg, prod_vld_reg;

    // 9*est + 16*sample + 5, then divided by ten as (acc >> 1) / 5.
    assign acc_next  = ACC_W'({est_reg, 3'b000}) + ACC_W'(est_reg)
                     + ACC_W'({decode_us, 4'b0000}) + ACC_W'(5);
    assign prod_next = PROD_W'(acc_reg[ACC_W-1:1]) * PROD_W'(DIV5_RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_vld_reg  <= 1'b0;
            prod_vld_reg <= 1'b0;
            est_reg      <= EST_RESET;
        end else begin
            acc_vld_reg  <= start;
            prod_vld_reg <= acc_vld_reg;
            if (prod_vld_reg) begin
                est_reg <= prod_reg[DIV5_SHIFT +: EST_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= acc_next;
        end
        if (acc_vld_reg) begin
            prod_reg <= prod_next;
        end
    end

    assign est  = est_reg;
    assign busy = acc_vld_reg | prod_vld_reg;

endmodule

// ----- design/deadline_aware_batch_scheduler.sv -----
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_item  (op, model, tag, time, decode sample)
// m_        out        m_valid / m_ready  m_item  (kind, model, tag, batch size, last, slack)
// cfg_      in         cfg_we             cfg_index, cfg_data (write only, no wait)
//
// An arrival is accepted in idle and its result is loaded in the execute state. A decode
// sample holds s_ready low after its execute state while the two-stage divide-by-ten
// pipeline settles.
// A poll scans each active queue in turn, with a memory read, age and slack compare
// for a nonempty queue and just the scan step for an empty one, then a fetch and an
// emit step per released batch member, each member one read of the tag/time memory.
// Reset is synchronous: queue heads and counts, configuration and the decode estimate
// return to their reset values at once; the tag/time memory is not cleared.
// A stalled result channel freezes the sequencer in the state that loads the result.
module deadline_aware_batch_scheduler #(
    parameter int NUM_MODELS  = 4,
    parameter int QUEUE_DEPTH = 64,
    parameter int MAX_BATCH   = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  dabs_pkg::in_item_t              s_item,
    output logic                            m_valid,
    input  logic                            m_ready,
    output dabs_pkg::out_item_t             m_item,
    input  logic                            cfg_we,
    input  logic [dabs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dabs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dabs_pkg::*;

    localparam int HEAD_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam int ADDR_W  = $clog2(NUM_MODELS * QUEUE_DEPTH);
    localparam int CMP_W   = (CNT_W > BSIZE_W) ? CNT_W : BSIZE_W;
    localparam int ENTRY_W = TAG_W + TIME_W;
    localparam int WIDE_W  = SLACK_W + 2;

    // Sequencer and item registers.
    sched_state_t state_reg, state_next;
    in_item_t     item_reg;
    logic         m_valid_reg, m_valid_next;
    out_item_t    out_reg, out_next;
    logic         out_load;
    logic         out_free;

    // Configuration registers.
    logic [TARGET_W-1:0] target_reg;
    logic [MARGIN_W-1:0] margin_reg;
    logic [MAXB_W-1:0]   maxb_reg;
    logic [EXEC_W-1:0]   exec_reg;
    logic [MODELS_W-1:0] models_reg;

    // Per-queue ring pointers.
    logic [HEAD_W-1:0] head_reg [NUM_MODELS];
    logic [HEAD_W-1:0] head_next [NUM_MODELS];
    logic [CNT_W-1:0]  count_reg [NUM_MODELS];
    logic [CNT_W-1:0]  count_next [NUM_MODELS];

    // Poll scan state.
    logic [MODEL_W-1:0]        scan_reg, scan_next;
    logic [MODEL_W-1:0]        pick_reg, pick_next;
    logic                      found_reg, found_next;
    logic                      fire_reg, fire_next;
    logic signed [SLACK_W-1:0] best_reg, best_next;
    logic signed [BASE_W-1:0]  base_reg, base_next;
    logic [TIME_W-1:0]         age_reg, age_next;
    logic [BSIZE_W-1:0]        bsize_reg, bsize_next;
    logic [BSIZE_W-1:0]        emit_reg, emit_next;

    // Selected queue and derived values.
    logic [MODELS_W-1:0]     active_n, last_model;
    logic [MODEL_W-1:0]      sel_model;
    logic [HEAD_W-1:0]       sel_head, head_inc;
    logic [CNT_W-1:0]        sel_count;
    logic                    sel_active;
    logic [EXEC_FIELD_W-1:0] sel_exec;
    logic [BSIZE_W-1:0]      sel_raw_limit, sel_limit;
    logic [ADDR_W-1:0]       queue_base;
    logic [SUM_W-1:0]        tail_sum;
    logic [HEAD_W-1:0]       tail_pos;
    logic                    arr_ok;
    logic [EST_W:0]          est_round;
    logic [EST_W-4:0]        dec_whole;
    logic signed [WIDE_W-1:0]  slack_wide;
    logic signed [SLACK_W-1:0] slack_sat;
    logic                    is_ready, take;
    logic                    scan_done, emit_last;

    // Memory and estimator.
    logic                ram_we, ram_re;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
    logic                ema_start, ema_busy;
    logic [EST_W-1:0]    est;

    // Tags and arrival times of all queues share one memory; queue m owns the
    // rows m*QUEUE_DEPTH up to m*QUEUE_DEPTH + QUEUE_DEPTH - 1 as a ring.
    dabs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_MODELS * QUEUE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dabs_ema u_ema (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (ema_start),
        .decode_us (item_reg.decode_us),
        .est       (est),
        .busy      (ema_busy)
    );

    // The block works on one item at a time; a waiting result does not block
    // acceptance because it sits in its own output register.
    assign s_ready  = (state_reg == ST_IDLE) && !ema_busy;
    assign m_valid  = m_valid_reg;
    assign m_item   = out_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        if (models_reg == '0) begin
            active_n = MODELS_W'(1);
        end else if (models_reg > MODELS_W'(NUM_MODELS)) begin
            active_n = MODELS_W'(NUM_MODELS);
        end else begin
            active_n = models_reg;
        end
    end
    assign last_model = active_n - 1'b1;

    // One queue is looked at per cycle: the arrival's model, the scanned one,
    // or the picked one while a batch drains.
    always_comb begin
        unique case (state_reg) inside
            ST_EXEC:                 sel_model = item_reg.model;
            ST_SCAN, ST_AGE, ST_CMP: sel_model = scan_reg;
            default:                 sel_model = pick_reg;
        endcase
    end

    always_comb begin
        sel_head  = '0;
        sel_count = '0;
        for (int i = 0; i < NUM_MODELS; i++) begin
            if (sel_model == MODEL_W'(i)) begin
                sel_head  = head_reg[i];
                sel_count = count_reg[i];
            end
        end
    end

    assign sel_active    = {1'b0, sel_model} < active_n;
    assign sel_exec      = exec_reg[EXEC_FIELD_W*sel_model +: EXEC_FIELD_W];
    assign sel_raw_limit = maxb_reg[BSIZE_W*sel_model +: BSIZE_W];

    always_comb begin
        if (sel_raw_limit == '0) begin
            sel_limit = BSIZE_W'(1);
        end else if (sel_raw_limit > BSIZE_W'(MAX_BATCH)) begin
            sel_limit = BSIZE_W'(MAX_BATCH);
        end else begin
            sel_limit = sel_raw_limit;
        end
    end

    assign head_inc = (sel_head == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : sel_head + 1'b1;

    // The tail is head + count folded once into the ring; the head stays below the depth and the count at or below it.
    assign tail_sum = SUM_W'(sel_head) + SUM_W'(sel_count);
    assign tail_pos = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                      HEAD_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : HEAD_W'(tail_sum);
    assign arr_ok   = sel_active && (sel_count != CNT_W'(QUEUE_DEPTH));

    assign queue_base = ADDR_W'(sel_model) * ADDR_W'(QUEUE_DEPTH);
    assign ram_raddr  = queue_base + ADDR_W'(sel_head);
    assign ram_waddr  = queue_base + ADDR_W'(tail_pos);
    assign ram_wdata  = {item_reg.request_tag, item_reg.now_us};

    // Decode estimate rounded to whole microseconds.
    assign est_round = {1'b0, est} + (EST_W + 1)'(8);
    assign dec_whole = est_round[EST_W:4];

    // Slack is base - age, exact in 34 bits, then clamped to the 32-bit range.
    assign slack_wide = WIDE_W'(base_reg) - $signed({2'b00, age_reg});

    always_comb begin
        if (slack_wide[WIDE_W-1:SLACK_W-1] == '0 || slack_wide[WIDE_W-1:SLACK_W-1] == '1) begin
            slack_sat = slack_wide[SLACK_W-1:0];
        end else if (slack_wide[WIDE_W-1]) begin
            slack_sat = SLACK_MIN;
        end else begin
            slack_sat = SLACK_MAX;
        end
    end

    // A ready queue beats an unready one; otherwise the smaller slack wins.
    // The scan runs upward, so a tie keeps the lower model.
    assign is_ready  = (CMP_W'(sel_count) >= CMP_W'(sel_limit)) || (slack_sat <= 0);
    assign take      = !found_reg || (is_ready && !fire_reg) ||
                       ((is_ready == fire_reg) && (slack_sat < best_reg));
    assign scan_done = ({1'b0, scan_reg} == last_model);
    assign emit_last = (BSIZE_W'(emit_reg + 1'b1) == bsize_reg);

    always_comb begin
        state_next = state_reg;
        out_load   = 1'b0;
        out_next   = out_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ema_start  = 1'b0;
        scan_next  = scan_reg;
        pick_next  = pick_reg;
        found_next = found_reg;
        fire_next  = fire_reg;
        best_next  = best_reg;
        base_next  = base_reg;
        age_next   = age_reg;
        bsize_next = bsize_reg;
        emit_next  = emit_reg;
        for (int i = 0; i < NUM_MODELS; i++) begin
            head_next[i]  = head_reg[i];
            count_next[i] = count_reg[i];
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC: begin
                unique case (item_reg.op)
                    OP_ARRIVAL: begin
                        if (out_free) begin
                            out_load              = 1'b1;
                            out_next.kind         = arr_ok ? KIND_ACCEPTED : KIND_REJECTED;
                            out_next.picked_model = item_reg.model;
                            out_next.out_tag      = item_reg.request_tag;
                            out_next.batch_size   = '0;
                            out_next.last         = 1'b1;
                            out_next.slack_us     = '0;
                            if (arr_ok) begin
                                ram_we = 1'b1;
                                for (int i = 0; i < NUM_MODELS; i++) begin
                                    if (sel_model == MODEL_W'(i)) begin
                                        count_next[i] = sel_count + 1'b1;
                                    end
                                end
                            end
                            state_next = ST_IDLE;
                        end
                    end
                    OP_POLL: begin
                        scan_next  = '0;
                        pick_next  = '0;
                        found_next = 1'b0;
                        fire_next  = 1'b0;
                        best_next  = '0;
                        state_next = ST_SCAN;
                    end
                    OP_DECODE: begin
                        ema_start  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    OP_NOP: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_SCAN: begin
                if (sel_active && sel_count != '0) begin
                    // Fetch the oldest entry and fold the per-model constants.
                    ram_re     = 1'b1;
                    base_next  = BASE_W'(target_reg) - BASE_W'(sel_exec)
                               - BASE_W'(dec_whole) - BASE_W'(margin_reg);
                    state_next = ST_AGE;
                end else if (scan_done) begin
                    state_next = ST_DECIDE;
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            ST_AGE: begin
                age_next   = item_reg.now_us - ram_rdata[TIME_W-1:0];
                state_next = ST_CMP;
            end

            ST_CMP: begin
                if (take) begin
                    found_next = 1'b1;
                    pick_next  = scan_reg;
                    best_next  = slack_sat;
                    fire_next  = fire_reg || is_ready;
                end
                if (scan_done) begin
                    state_next = ST_DECIDE;
                end else begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = ST_SCAN;
                end
            end

            ST_DECIDE: begin
                if (!found_reg || !fire_reg) begin
                    if (out_free) begin
                        out_load              = 1'b1;
                        out_next.kind         = found_reg ? KIND_WAITING : KIND_EMPTY;
                        out_next.picked_model = found_reg ? pick_reg : '0;
                        out_next.out_tag      = '0;
                        out_next.batch_size   = '0;
                        out_next.last         = 1'b1;
                        out_next.slack_us     = found_reg ? best_reg : '0;
                        state_next            = ST_IDLE;
                    end
                end else begin
                    bsize_next = (CMP_W'(sel_count) < CMP_W'(sel_limit)) ?
                                 BSIZE_W'(sel_count) : sel_limit;
                    emit_next  = '0;
                    state_next = ST_FETCH;
                end
            end

            ST_FETCH: begin
                ram_re     = 1'b1;
                state_next = ST_EMIT;
            end

            ST_EMIT: begin
                // The read data stays put while the result channel stalls.
                if (out_free) begin
                    out_load              = 1'b1;
                    out_next.kind         = KIND_MEMBER;
                    out_next.picked_model = pick_reg;
                    out_next.out_tag      = ram_rdata[ENTRY_W-1:TIME_W];
                    out_next.batch_size   = bsize_reg;
                    out_next.last         = emit_last;
                    out_next.slack_us     = best_reg;
                    for (int i = 0; i < NUM_MODELS; i++) begin
                        if (sel_model == MODEL_W'(i)) begin
                            head_next[i]  = head_inc;
                            count_next[i] = sel_count - 1'b1;
                        end
                    end
                    emit_next  = emit_reg + 1'b1;
                    state_next = emit_last ? ST_IDLE : ST_FETCH;
                end
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            found_reg   <= 1'b0;
            fire_reg    <= 1'b0;
            for (int i = 0; i < NUM_MODELS; i++) begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            found_reg   <= found_next;
            fire_reg    <= fire_next;
            for (int i = 0; i < NUM_MODELS; i++) begin
                head_reg[i]  <= head_next[i];
                count_reg[i] <= count_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
        out_reg   <= out_next;
        scan_reg  <= scan_next;
        pick_reg  <= pick_next;
        best_reg  <= best_next;
        base_reg  <= base_next;
        age_reg   <= age_next;
        bsize_reg <= bsize_next;
        emit_reg  <= emit_next;
    end

    // Configuration writes; an unknown index is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= TARGET_RESET;
            margin_reg <= MARGIN_RESET;
            maxb_reg   <= MAXB_RESET;
            exec_reg   <= EXEC_RESET;
            models_reg <= MODELS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_TARGET: target_reg <= cfg_data[TARGET_W-1:0];
                CFG_MARGIN: margin_reg <= cfg_data[MARGIN_W-1:0];
                CFG_MAXB:   maxb_reg   <= cfg_data[MAXB_W-1:0];
                CFG_EXEC:   exec_reg   <= cfg_data[EXEC_W-1:0];
                CFG_MODELS: models_reg <= cfg_data[MODELS_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- design/dabs_checker.sv -----
module dabs_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input dabs_pkg::out_item_t m_item,
    input logic                m_valid,
    input logic                m_ready
);
    import dabs_pkg::*;

    // A result that waits keeps its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // Items are worked one at a time: no acceptance right after another.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted while the previous one is in work");

    // Every result other than a batch member stands alone.
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.kind != KIND_MEMBER |-> m_item.last)
        else $error("single result without last");

    // A batch member always reports a nonzero batch size.
    a_member_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.kind == KIND_MEMBER |-> m_item.batch_size != '0)
        else $error("batch member with empty batch");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind deadline_aware_batch_scheduler dabs_checker u_dabs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_item  (m_item),
    .m_valid (m_valid),
    .m_ready (m_ready)
);
